@@ sv/plane_dedup_table_defines.svh @@
// ----------------------------------------------------------------------------
// plane_dedup_table_defines: assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PLANE_DEDUP_TABLE_DEFINES_SVH
`define PLANE_DEDUP_TABLE_DEFINES_SVH

// condition holds at every edge
`define PDT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PDT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdt_pkg: plane dedup table package
// sizes, codes and the compare packet shared by the table modules
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int NRM_W   = 20;
    localparam int DST_W   = 27;
    localparam int VAL_W   = 27;
    localparam int NTOL_W  = 19;
    localparam int DTOL_W  = 16;
    localparam int TOL_W   = 19;
    localparam int IDX_W   = 11;
    localparam int CNTO_W  = 12;
    localparam int LANES   = 4;
    localparam int NUM_CELLS = 4;
    localparam int ENTRY_W = 3 * NRM_W + DST_W + 3;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 120;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [1:0] {
        ACT_FIND  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_READ     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_TOL = 1'd0,
        CFG_DIST_TOL   = 1'd1
    } cfg_idx_t;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [TOL_W-1:0] tol_t;

    // one stored entry on its way down the compare row
    typedef struct packed {
        logic                  valid;
        logic [ADDR_W-1:0]     idx;
        val_t [LANES-1:0]      ent;
        val_t [LANES-1:0]      qry;
        tol_t [LANES-1:0]      tol;
        logic                  dir;
        logic                  neg;
    } pkt_t;

endpackage

@@ sv/plane_dedup_table.sv @@
// ----------------------------------------------------------------------------
// plane_dedup_table: tolerant plane deduplication table
// stores planes once, matching new planes directly or negated within tolerances
// ----------------------------------------------------------------------------
// A find beat reads the table from entry 0 upward, one entry per cycle from
// the table ram, and streams each entry through a row of four compare cells
// (x, y, z, distance), and ends early on the first match. One beat is worked
// on at a time; the result register lets a new beat be taken while the
// previous result waits for m_tready. No clearing pass is needed after reset:
// entries at or above the count are never looked at.
// ----------------------------------------------------------------------------
`include "plane_dedup_table_defines.svh"

module plane_dedup_table
    import pdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: action[2], normal_x[20], normal_y[20], normal_z[20],
    //                      plane_dist[27], read_index[11], zero pad[4]
    input  logic [IN_W-1:0]       s_tdata,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: status[3], plane_index[11], match_flipped[1],
    //                      out_normal_x[20], out_normal_y[20], out_normal_z[20],
    //                      out_dist[27], out_sign_bits[3], entry_count[12], pad[3]
    output logic [OUT_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EMIT
    } state_t;

    // input fields
    logic [1:0]       in_action;
    logic [NRM_W-1:0] in_nx;
    logic [NRM_W-1:0] in_ny;
    logic [NRM_W-1:0] in_nz;
    logic [DST_W-1:0] in_dist;
    logic [IDX_W-1:0] in_ri;
    logic             accept;

    assign in_action = s_tdata[1:0];
    assign in_nx     = s_tdata[21:2];
    assign in_ny     = s_tdata[41:22];
    assign in_nz     = s_tdata[61:42];
    assign in_dist   = s_tdata[88:62];
    assign in_ri     = s_tdata[99:89];

    state_t              state_reg;
    logic [NTOL_W-1:0]   ntol_reg;
    logic [DTOL_W-1:0]   dtol_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                issue_q_reg;
    logic [ADDR_W-1:0]   issue_idx_reg;

    // query held for the whole beat
    logic [NRM_W-1:0]    q_nx_reg;
    logic [NRM_W-1:0]    q_ny_reg;
    logic [NRM_W-1:0]    q_nz_reg;
    logic [DST_W-1:0]    q_dist_reg;
    logic [IDX_W-1:0]    q_ri_reg;

    // pending result
    status_t             res_status_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                res_flip_reg;
    logic [NRM_W-1:0]    res_nx_reg;
    logic [NRM_W-1:0]    res_ny_reg;
    logic [NRM_W-1:0]    res_nz_reg;
    logic [DST_W-1:0]    res_dist_reg;
    logic [2:0]          res_sign_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // table ram and compare row
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    pkt_t                chain [NUM_CELLS+1];
    logic                flush;
    logic                issue;
    logic                busy;
    logic                hit;
    logic                scan_done;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // entry word: sign bits on top, then distance, z, y, x
    assign ram_wdata = {q_nz_reg[NRM_W-1], q_ny_reg[NRM_W-1], q_nx_reg[NRM_W-1],
                        q_dist_reg, q_nz_reg, q_ny_reg, q_nx_reg};
    assign ram_raddr = (state_reg == S_IDLE) ? ADDR_W'(in_ri) : scan_idx_reg[ADDR_W-1:0];

    pdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // feed of the compare row: entry just read plus query and tolerances
    always_comb
    begin
        chain[0].valid  = issue_q_reg & (state_reg == S_SCAN);
        chain[0].idx    = issue_idx_reg;
        chain[0].ent[0] = VAL_W'($signed(ram_rdata[NRM_W-1:0]));
        chain[0].ent[1] = VAL_W'($signed(ram_rdata[2*NRM_W-1:NRM_W]));
        chain[0].ent[2] = VAL_W'($signed(ram_rdata[3*NRM_W-1:2*NRM_W]));
        chain[0].ent[3] = VAL_W'($signed(ram_rdata[3*NRM_W+DST_W-1:3*NRM_W]));
        chain[0].qry[0] = VAL_W'($signed(q_nx_reg));
        chain[0].qry[1] = VAL_W'($signed(q_ny_reg));
        chain[0].qry[2] = VAL_W'($signed(q_nz_reg));
        chain[0].qry[3] = VAL_W'($signed(q_dist_reg));
        chain[0].tol[0] = TOL_W'(ntol_reg);
        chain[0].tol[1] = TOL_W'(ntol_reg);
        chain[0].tol[2] = TOL_W'(ntol_reg);
        chain[0].tol[3] = TOL_W'(dtol_reg);
        chain[0].dir    = 1'b1;
        chain[0].neg    = 1'b1;
    end

    assign flush = (state_reg != S_SCAN) | hit;

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        pdt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .flush (flush),
            .pin   (chain[c]),
            .pout  (chain[c+1])
        );
    end

    always_comb
    begin
        busy = issue_q_reg;
        for (int c = 1; c <= NUM_CELLS; c++)
        begin
            busy = busy | chain[c].valid;
        end
    end

    // entries leave the row in table order, so the first hit is the earliest
    assign issue     = scan_idx_reg < count_reg;
    assign hit       = (state_reg == S_SCAN) & chain[NUM_CELLS].valid &
                       (chain[NUM_CELLS].dir | chain[NUM_CELLS].neg);
    assign scan_done = (state_reg == S_SCAN) & ~hit & ~issue & ~busy;
    assign ram_we    = scan_done & (32'(count_reg) < TABLE_DEPTH);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntol_reg <= NTOL_W'(26);
            dtol_reg <= DTOL_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_TOL: ntol_reg <= cfg_data[NTOL_W-1:0];
                CFG_DIST_TOL:   dtol_reg <= cfg_data[DTOL_W-1:0];
                default: ;
            endcase
        end
    end

    // read issue tracking for the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_q_reg <= 1'b0;
        end
        else
        begin
            issue_q_reg <= (state_reg == S_SCAN) & issue & ~hit;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= scan_idx_reg[ADDR_W-1:0];
    end

    // control state machine and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            q_nx_reg       <= '0;
            q_ny_reg       <= '0;
            q_nz_reg       <= '0;
            q_dist_reg     <= '0;
            q_ri_reg       <= '0;
            res_status_reg <= ST_FOUND;
            res_idx_reg    <= '0;
            res_flip_reg   <= 1'b0;
            res_nx_reg     <= '0;
            res_ny_reg     <= '0;
            res_nz_reg     <= '0;
            res_dist_reg   <= '0;
            res_sign_reg   <= '0;
        end
        else
        begin
            // in the emit state the output register is reloaded below instead
            if (out_valid_reg && m_tready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        q_nx_reg     <= in_nx;
                        q_ny_reg     <= in_ny;
                        q_nz_reg     <= in_nz;
                        q_dist_reg   <= in_dist;
                        q_ri_reg     <= in_ri;
                        res_idx_reg  <= '0;
                        res_flip_reg <= 1'b0;
                        res_nx_reg   <= '0;
                        res_ny_reg   <= '0;
                        res_nz_reg   <= '0;
                        res_dist_reg <= '0;
                        res_sign_reg <= '0;
                        scan_idx_reg <= '0;
                        if (in_action == ACT_CLEAR)
                        begin
                            count_reg      <= '0;
                            res_status_reg <= ST_CLEARED;
                            state_reg      <= S_EMIT;
                        end
                        else if (in_action[1])
                        begin
                            // action three decodes as a read too
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_READ:
                begin
                    res_status_reg <= ST_READ;
                    res_idx_reg    <= q_ri_reg;
                    if (32'(q_ri_reg) < 32'(count_reg))
                    begin
                        res_nx_reg   <= ram_rdata[NRM_W-1:0];
                        res_ny_reg   <= ram_rdata[2*NRM_W-1:NRM_W];
                        res_nz_reg   <= ram_rdata[3*NRM_W-1:2*NRM_W];
                        res_dist_reg <= ram_rdata[3*NRM_W+DST_W-1:3*NRM_W];
                        res_sign_reg <= ram_rdata[ENTRY_W-1:3*NRM_W+DST_W];
                    end
                    state_reg <= S_EMIT;
                end

                S_SCAN:
                begin
                    if (issue && !hit)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        res_status_reg <= ST_FOUND;
                        res_idx_reg    <= IDX_W'(chain[NUM_CELLS].idx);
                        // direct match wins when both hold
                        res_flip_reg   <= ~chain[NUM_CELLS].dir;
                        state_reg      <= S_EMIT;
                    end
                    else if (scan_done)
                    begin
                        if (ram_we)
                        begin
                            res_status_reg <= ST_INSERTED;
                            res_idx_reg    <= IDX_W'(count_reg);
                            count_reg      <= count_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                        end
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'b000, CNTO_W'(count_reg), res_sign_reg,
                                          res_dist_reg, res_nz_reg, res_ny_reg,
                                          res_nx_reg, res_flip_reg, res_idx_reg,
                                          res_status_reg};
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PDT_ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= TABLE_DEPTH, "plane count beyond table depth")
    `PDT_ASSERT_IMPL(a_scan_bound, state_reg == S_SCAN, scan_idx_reg <= count_reg, "scan ran past count")
    `PDT_ASSERT_IMPL(a_insert_room, ram_we, 32'(count_reg) < TABLE_DEPTH, "insert into full table")
    `PDT_ASSERT_NEXT(a_clear_empties, accept && in_action == ACT_CLEAR, count_reg == '0, "clear left entries")

endmodule

@@ sv/pdt_ram.sv @@
// ----------------------------------------------------------------------------
// pdt_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/pdt_cell.sv @@
// ----------------------------------------------------------------------------
// pdt_cell: one compare cell of the row
// checks lane 0 direct and negated, then rotates the lanes to the next cell
// ----------------------------------------------------------------------------
module pdt_cell
    import pdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic flush,
    input  pkt_t pin,
    output pkt_t pout
);

    logic signed [VAL_W+1:0] d_dir;
    logic signed [VAL_W+1:0] d_neg;
    logic        [VAL_W+1:0] a_dir;
    logic        [VAL_W+1:0] a_neg;
    logic                    ok_dir;
    logic                    ok_neg;
    pkt_t                    pkt_next;
    logic                    valid_reg;
    pkt_t                    pkt_reg;

    always_comb
    begin
        d_dir  = (VAL_W+2)'($signed(pin.ent[0])) - (VAL_W+2)'($signed(pin.qry[0]));
        d_neg  = (VAL_W+2)'($signed(pin.ent[0])) + (VAL_W+2)'($signed(pin.qry[0]));
        a_dir  = (d_dir < 0) ? $unsigned(-d_dir) : $unsigned(d_dir);
        a_neg  = (d_neg < 0) ? $unsigned(-d_neg) : $unsigned(d_neg);
        ok_dir = a_dir < (VAL_W+2)'(pin.tol[0]);
        ok_neg = a_neg < (VAL_W+2)'(pin.tol[0]);

        pkt_next = pin;
        for (int j = 0; j < LANES - 1; j++)
        begin
            pkt_next.ent[j] = pin.ent[j+1];
            pkt_next.qry[j] = pin.qry[j+1];
            pkt_next.tol[j] = pin.tol[j+1];
        end
        pkt_next.ent[LANES-1] = pin.ent[0];
        pkt_next.qry[LANES-1] = pin.qry[0];
        pkt_next.tol[LANES-1] = pin.tol[0];
        pkt_next.dir = pin.dir & ok_dir;
        pkt_next.neg = pin.neg & ok_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pin.valid & ~flush;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    always_comb
    begin
        pout       = pkt_reg;
        pout.valid = valid_reg;
    end

endmodule
